>>> sv/fp8as_pkg.sv
// Package: shared types and constants for the E5M2 adder/subtractor.
package fp8as_pkg;

    localparam int unsigned PipeDepth = 3;

    localparam logic [7:0] NAN_CODE     = 8'h7d;
    localparam logic [7:0] POS_INF_CODE = 8'h7c;
    localparam logic [7:0] NEG_INF_CODE = 8'hfc;
    localparam logic [4:0] EXP_ALL_ONES = 5'h1f;

    // stage 1 -> stage 2: aligned operands
    typedef struct packed {
        logic        special;
        logic [7:0]  special_value;
        logic        sa;
        logic        sb;
        logic [5:0]  e;
        logic [18:0] ma;
        logic [18:0] mb;
    } align_t;

    // stage 2 -> stage 3: combined magnitude
    typedef struct packed {
        logic        special;
        logic [7:0]  special_value;
        logic        s;
        logic [5:0]  e;
        logic [18:0] m;
    } sum_t;

endpackage

>>> sv/fp8as_align.sv
// Stage 1: special cases, unpack and alignment.
module fp8as_align
    import fp8as_pkg::*;
(
    input  logic       cmd,
    input  logic [7:0] operand_a,
    input  logic [7:0] operand_b,
    output align_t     align
);

    logic [7:0]  b;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [5:0]  ea, eb;
    logic [18:0] ma, mb;
    logic [5:0]  d;

    always_comb
    begin
        b      = {operand_b[7] ^ cmd, operand_b[6:0]};
        nan_a  = operand_a[6:2] == EXP_ALL_ONES && operand_a[1:0] != 2'd0;
        nan_b  = b[6:2] == EXP_ALL_ONES && b[1:0] != 2'd0;
        inf_a  = operand_a[6:2] == EXP_ALL_ONES && operand_a[1:0] == 2'd0;
        inf_b  = b[6:2] == EXP_ALL_ONES && b[1:0] == 2'd0;
        zero_a = operand_a[6:0] == 7'd0;
        zero_b = b[6:0] == 7'd0;
        align.special = 1'b1;
        priority if (nan_a || nan_b)
            align.special_value = NAN_CODE;
        else if (inf_a && inf_b && operand_a[7] != b[7])
            align.special_value = NAN_CODE;
        else if (inf_a)
            align.special_value = operand_a;
        else if (inf_b)
            align.special_value = b;
        else if (zero_a)
            align.special_value = b;
        else if (zero_b)
            align.special_value = operand_a;
        else
        begin
            align.special       = 1'b0;
            align.special_value = 8'd0;
        end
        ea = (operand_a[6:2] == 5'd0) ? 6'd1 : {1'b0, operand_a[6:2]};
        eb = (b[6:2] == 5'd0) ? 6'd1 : {1'b0, b[6:2]};
        ma = {2'b0, operand_a[6:2] != 5'd0, operand_a[1:0], 14'd0} << 1;
        mb = {2'b0, b[6:2] != 5'd0, b[1:0], 14'd0} << 1;
        align.sa = operand_a[7];
        align.sb = b[7];
        if (ea > eb)
        begin
            d        = ea - eb;
            align.e  = ea;
            align.ma = ma;
            align.mb = mb >> d;
        end
        else
        begin
            d        = eb - ea;
            align.e  = eb;
            align.ma = ma >> d;
            align.mb = mb;
        end
    end

endmodule

>>> sv/fp8as_combine.sv
// Stage 2: magnitude add or subtract.
module fp8as_combine
    import fp8as_pkg::*;
(
    input  align_t align,
    output sum_t   sum
);

    always_comb
    begin
        sum.special       = align.special;
        sum.special_value = align.special_value;
        sum.e             = align.e;
        if (align.sa != align.sb)
        begin
            if (align.ma > align.mb)
            begin
                sum.m = align.ma - align.mb;
                sum.s = align.sa;
            end
            else
            begin
                sum.m = align.mb - align.ma;
                sum.s = align.sb;
            end
        end
        else
        begin
            sum.m = align.ma + align.mb;
            sum.s = align.sa;
        end
    end

endmodule

>>> sv/fp8as_round.sv
// Stage 3: normalise, round to nearest even and pack.
module fp8as_round
    import fp8as_pkg::*;
(
    input  sum_t       sum,
    output logic [7:0] result
);

    logic [18:0]       m;
    logic signed [7:0] e;
    logic              sticky;
    logic [4:0]        lz;
    logic [3:0]        r;
    logic              g, l;

    always_comb
    begin
        m      = sum.m;
        e      = $signed({2'b00, sum.e});
        sticky = 1'b0;
        lz     = 5'd0;
        if (m[18])
        begin
            e      = e + 8'sd1;
            sticky = m[0];
            m      = m >> 1;
        end
        else
        begin
            for (int i = 17; i >= 0; i--)
                if (m[i] && lz == 5'd0 && !m[17])
                    lz = 5'(17 - i);
            e = e - $signed({3'b000, lz});
            m = m << lz;
        end
        l      = m[15];
        g      = m[14];
        sticky = sticky | (m[13:0] != 14'd0);
        r      = {1'b0, m[17:15]} + {3'd0, g & (l | sticky)};
        if (r[3])
        begin
            e = e + 8'sd1;
            r = r >> 1;
        end
        if (sum.special)
            result = sum.special_value;
        else if (sum.m == 19'd0)
            result = 8'h00;
        else if (e >= 8'sd31)
            result = sum.s ? NEG_INF_CODE : POS_INF_CODE;
        else if (e <= -8'sd2)
            result = 8'h00;
        else if (e == -8'sd1)
            result = {sum.s, 5'd0, r[3:2]};
        else if (e == 8'sd0)
            result = {sum.s, 5'd0, r[2:1]};
        else
            result = {sum.s, e[4:0], r[1:0]};
    end

endmodule

>>> sv/fp8_e5m2_add_sub.sv
// Top level: pipelined E5M2 add/subtract with stream handshake.
// The result is registered in align_reg, sum_reg and res_reg in turn before it appears on m_tdata.
// Throughput: one item per cycle while the output is not stalled, set by the three register stages.
// A stall freezes every full stage back to the first empty one; an empty stage still fills while stalled.
// Reset (rst_n low, asynchronous) clears all stage valid bits.
module fp8_e5m2_add_sub
    import fp8as_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // operand_a, operand_b
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // sum_value
);

    align_t     align_next, align_reg;
    sum_t       sum_next, sum_reg;
    logic [7:0] res_next, res_reg;
    logic       v1_reg, v2_reg, v3_reg;
    logic       en1, en2, en3;

    fp8as_align  u_align (.cmd(s_tuser), .operand_a(s_tdata[7:0]),
                          .operand_b(s_tdata[15:8]), .align(align_next));
    fp8as_combine u_comb (.align(align_reg), .sum(sum_next));
    fp8as_round  u_round (.sum(sum_reg), .result(res_next));

    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign m_tvalid = v3_reg;
    assign m_tdata  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1) align_reg <= align_next;
        if (en2) sum_reg   <= sum_next;
        if (en3) res_reg   <= res_next;
    end

endmodule

>>> sv/fp8as_checker.sv
// Checker: port-level properties of the adder, bound to the top level.
module fp8as_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed under stall");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("item lost in pipeline");

    a_nan: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[6:2] == 5'h1f |-> m_tdata[1:0] == 2'd0 || m_tdata == 8'h7d)
        else $error("non-canonical NaN");

endmodule

bind fp8_e5m2_add_sub fp8as_checker u_checker (.*);
